>>> src/natural_log_approximator_unit_defines.svh
// assertion macros used by the natural log approximator top level
`ifndef NATURAL_LOG_APPROXIMATOR_UNIT_DEFINES_SVH
`define NATURAL_LOG_APPROXIMATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define NLA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nla assertion failed");

// next-cycle implication
`define NLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nla assertion failed");

`endif

>>> src/nla_pkg.sv
// shared types, constants and coefficient helpers for the natural log approximator
package nla_pkg;

   localparam int FRAC_BITS_DEFAULT = 24;
   localparam int SRC_FRAC          = 28;
   localparam int MANT_BITS         = 23;
   localparam int EXP_BIAS          = 127;
   localparam int EXP_ALL_ONES      = 255;
   localparam int NUM_CELLS         = 4;

   // coefficient magnitudes with 28 fraction bits
   localparam int K4_Q28  = 120038846;
   localparam int K5_Q28  = 15185622;
   localparam int K3_Q28  = 394588524;
   localparam int K2_Q28  = 757310806;
   localparam int K1_Q28  = 467559240;
   localparam int LN2_Q28 = 186065279;

   typedef struct packed {
      logic                 invalid;
      logic                 eob;
      logic [MANT_BITS:0]   mant;
   } nla_tag_type;

   // round a 28-fraction-bit magnitude to frac bits, half away from zero
   function automatic logic [31:0] nla_to_frac(input int mag28, input int frac);
      int sh;
      logic [31:0] r;
      sh = SRC_FRAC - frac;
      if (sh <= 0) begin
         r = 32'(mag28);
      end else begin
         r = 32'((mag28 + (1 << (sh - 1))) >> sh);
      end
      return r;
   endfunction

   // additive coefficient of each horner step, highest order first
   function automatic logic signed [31:0] nla_step_coef(input int step, input int frac);
      logic signed [31:0] c;
      case (step)
         0: c = signed'(nla_to_frac(K4_Q28, frac));
         1: c = -signed'(nla_to_frac(K3_Q28, frac));
         2: c = signed'(nla_to_frac(K2_Q28, frac));
         3: c = -signed'(nla_to_frac(K1_Q28, frac));
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> src/nla_front.sv
// front stage: field decode, validity check and exponent term
module nla_front #(
   parameter int FRAC_BITS = nla_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [31:0]                sample_bits,
   input  logic                       end_of_block,
   output logic                       out_valid,
   input  logic                       out_ready,
   output nla_pkg::nla_tag_type       out_tag,
   output logic signed [FRAC_BITS+9:0] out_exp
);
   import nla_pkg::*;

   localparam int YW = FRAC_BITS + 10;
   localparam logic signed [FRAC_BITS:0] LN2 =
      signed'((FRAC_BITS + 1)'(nla_to_frac(LN2_Q28, FRAC_BITS)));

   logic                 valid_ff;
   nla_tag_type          tag_ff, tag_in;
   logic signed [YW-1:0] exp_ff, exp_in;
   logic [7:0]           expf;
   logic signed [8:0]    unb_exp;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_exp   = exp_ff;

   always_comb begin
      expf            = sample_bits[30:23];
      tag_in.invalid  = sample_bits[31] || (expf == '0) || (expf == 8'(EXP_ALL_ONES));
      tag_in.eob      = end_of_block;
      tag_in.mant     = {1'b1, sample_bits[MANT_BITS-1:0]};
      unb_exp         = signed'({1'b0, expf}) - 9'sd127;
      exp_in          = YW'(unb_exp) * YW'(LN2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tag_ff <= tag_in;
         exp_ff <= exp_in;
      end
   end

endmodule

>>> src/nla_cell.sv
// one horner cell: t_next = coef + round(t * m), rounding half away from zero
module nla_cell #(
   parameter int                 FRAC_BITS = nla_pkg::FRAC_BITS_DEFAULT,
   parameter logic signed [31:0] COEF      = '0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  nla_pkg::nla_tag_type        in_tag,
   input  logic signed [FRAC_BITS+3:0] in_t,
   input  logic signed [FRAC_BITS+9:0] in_exp,
   output logic                        out_valid,
   input  logic                        out_ready,
   output nla_pkg::nla_tag_type        out_tag,
   output logic signed [FRAC_BITS+3:0] out_t,
   output logic signed [FRAC_BITS+9:0] out_exp
);
   import nla_pkg::*;

   localparam int TW = FRAC_BITS + 4;
   localparam int YW = FRAC_BITS + 10;
   localparam int PW = TW + MANT_BITS + 1;
   localparam logic signed [TW-1:0] COEF_T = TW'(COEF);

   logic                 valid_ff;
   nla_tag_type          tag_ff;
   logic signed [TW-1:0] t_ff, t_in;
   logic signed [YW-1:0] exp_ff;
   logic                 neg;
   logic [TW-1:0]        abs_t;
   logic [PW-1:0]        prod;
   logic [TW-2:0]        rq;
   logic signed [TW-1:0] term;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_t     = t_ff;
   assign out_exp   = exp_ff;

   always_comb begin
      neg   = in_t[TW-1];
      abs_t = neg ? TW'(-in_t) : TW'(in_t);
      // magnitude product plus half an lsb of the 23-bit shift
      prod  = PW'(abs_t[TW-2:0]) * PW'(in_tag.mant) + PW'(1 << (MANT_BITS - 1));
      rq    = prod[MANT_BITS +: TW-1];
      term  = signed'({1'b0, rq});
      t_in  = COEF_T + (neg ? -term : term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tag_ff <= in_tag;
         t_ff   <= t_in;
         exp_ff <= in_exp;
      end
   end

endmodule

>>> src/nla_finish.sv
// final stage: exponent term plus polynomial, saturation, output register
module nla_finish #(
   parameter int FRAC_BITS = nla_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  nla_pkg::nla_tag_type        in_tag,
   input  logic signed [FRAC_BITS+3:0] in_t,
   input  logic signed [FRAC_BITS+9:0] in_exp,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [31:0]          log_value,
   output logic                        invalid_input,
   output logic                        end_of_block_out
);
   import nla_pkg::*;

   localparam int YW = FRAC_BITS + 10;
   localparam int SW = (YW > 33) ? YW : 33;
   localparam logic signed [SW-1:0] MAX_V = {{(SW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SW-1:0] MIN_V = {{(SW-31){1'b1}}, {31{1'b0}}};

   logic                 valid_ff;
   logic signed [31:0]   log_ff, log_in;
   logic                 inv_ff;
   logic                 eob_ff;
   logic signed [YW-1:0] y;
   logic signed [SW-1:0] y_ext;

   assign in_ready         = !valid_ff || out_ready;
   assign out_valid        = valid_ff;
   assign log_value        = log_ff;
   assign invalid_input    = inv_ff;
   assign end_of_block_out = eob_ff;

   always_comb begin
      y     = YW'(in_t) + in_exp;
      y_ext = SW'(y);
      if (in_tag.invalid) begin
         log_in = '0;
      end else if (y_ext > MAX_V) begin
         log_in = 32'sh7fff_ffff;
      end else if (y_ext < MIN_V) begin
         log_in = 32'sh8000_0000;
      end else begin
         log_in = y_ext[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         log_ff <= log_in;
         inv_ff <= in_tag.invalid;
         eob_ff <= in_tag.eob;
      end
   end

endmodule

>>> src/natural_log_approximator_unit.sv
// top level: float32 natural log approximator as a chain of horner cells
//
// channel | direction | words
// req_    | in        | sample_bits, end_of_block
// rsp_    | out       | log_value (signed, FRAC_BITS fraction bits), invalid_input,
//         |           | end_of_block_out
//
// one word per cycle while rsp_ready holds; stages are decode, four horner cells,
// and sum and saturate, each cell holding one multiplier of 27 by 24 bits.
// every stage has its own valid bit, so bubbles close up under a stalled output.
// req_ready is the front stage having room, through the chain of stage ready terms.
// reset clears the stage valid bits only.
`include "natural_log_approximator_unit_defines.svh"

module natural_log_approximator_unit #(
   parameter int FRAC_BITS = nla_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_sample_bits,
   input  logic               req_end_of_block,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_log_value,
   output logic               rsp_invalid_input,
   output logic               rsp_end_of_block_out
);
   import nla_pkg::*;

   localparam int TW = FRAC_BITS + 4;
   localparam int YW = FRAC_BITS + 10;
   // horner seed is the negated highest-order coefficient
   localparam logic signed [TW-1:0] T_SEED =
      -signed'(TW'(nla_to_frac(K5_Q28, FRAC_BITS)));

   logic                 cell_valid [NUM_CELLS+1];
   logic                 cell_ready [NUM_CELLS+1];
   nla_tag_type          cell_tag   [NUM_CELLS+1];
   logic signed [TW-1:0] cell_t     [NUM_CELLS+1];
   logic signed [YW-1:0] cell_exp   [NUM_CELLS+1];

   assign cell_t[0] = T_SEED;

   nla_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .sample_bits (req_sample_bits),
      .end_of_block(req_end_of_block),
      .out_valid   (cell_valid[0]),
      .out_ready   (cell_ready[0]),
      .out_tag     (cell_tag[0]),
      .out_exp     (cell_exp[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      nla_cell #(
         .FRAC_BITS(FRAC_BITS),
         .COEF     (nla_step_coef(g, FRAC_BITS))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (cell_valid[g]),
         .in_ready (cell_ready[g]),
         .in_tag   (cell_tag[g]),
         .in_t     (cell_t[g]),
         .in_exp   (cell_exp[g]),
         .out_valid(cell_valid[g+1]),
         .out_ready(cell_ready[g+1]),
         .out_tag  (cell_tag[g+1]),
         .out_t    (cell_t[g+1]),
         .out_exp  (cell_exp[g+1])
      );
   end

   nla_finish #(
      .FRAC_BITS(FRAC_BITS)
   ) u_finish (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (cell_valid[NUM_CELLS]),
      .in_ready        (cell_ready[NUM_CELLS]),
      .in_tag          (cell_tag[NUM_CELLS]),
      .in_t            (cell_t[NUM_CELLS]),
      .in_exp          (cell_exp[NUM_CELLS]),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .log_value       (rsp_log_value),
      .invalid_input   (rsp_invalid_input),
      .end_of_block_out(rsp_end_of_block_out)
   );

   // a flagged word always carries a zero result
   `NLA_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid_input, rsp_log_value == '0)
   // a word waiting at the last cell stays valid with its t and exp unchanged
   `NLA_ASSERT_NEXT(a_tail_held, clock, reset, cell_valid[NUM_CELLS] && !cell_ready[NUM_CELLS], cell_valid[NUM_CELLS] && $stable(cell_exp[NUM_CELLS]) && $stable(cell_t[NUM_CELLS]))
   // a negative sample is flagged at decode
   `NLA_ASSERT_NEXT(a_sign_flag, clock, reset, req_valid && req_ready && req_sample_bits[31], cell_valid[0] && cell_tag[0].invalid)

endmodule

>>> bench/natural_log_approximator_unit_test.sv
// self-checking bench for the natural log approximator: fixed-point predictor and random stalls
module natural_log_approximator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nla_pkg::*;

   localparam int FRAC_BITS    = FRAC_BITS_DEFAULT;
   localparam int RANDOM_WORDS = 1600;
   localparam int CALM_WORDS   = 120;

   typedef struct packed {
      logic [31:0] bits;
      logic        eob;
   } sample_word_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               invalid;
      logic               eob;
   } ln_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_sample_bits = '0;
   logic               req_end_of_block = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_log_value;
   logic               rsp_invalid_input;
   logic               rsp_end_of_block_out;

   sample_word_type samples_queued[$];
   ln_result_type   ln_due[$];
   sample_word_type next_sample;
   ln_result_type   due_word;
   int              send_gap = 0;
   int              stall_left = 0;
   int              fail_count = 0;
   logic            calm = 1'b0;

   natural_log_approximator_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_bits(req_sample_bits),
      .req_end_of_block(req_end_of_block),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_log_value(rsp_log_value),
      .rsp_invalid_input(rsp_invalid_input),
      .rsp_end_of_block_out(rsp_end_of_block_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // 28-fraction-bit magnitude rounded to FRAC_BITS, half away from zero
   function automatic longint fixed_coef(input int mag28);
      int sh;
      sh = SRC_FRAC - FRAC_BITS;
      if (sh <= 0) return longint'(mag28);
      return (longint'(mag28) + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   // product with the Q1.23 mantissa, back to FRAC_BITS, ties away from zero
   function automatic longint scale_by_mant(input longint a, input logic [23:0] m);
      logic   neg;
      longint mag;
      longint r;
      neg = a < 0;
      mag = (neg ? -a : a) * longint'(m);
      r = (mag + (longint'(1) << (MANT_BITS - 1))) >>> MANT_BITS;
      return neg ? -r : r;
   endfunction

   function automatic ln_result_type predict_log(input logic [31:0] bits, input logic eob);
      ln_result_type w;
      logic [7:0]    expf;
      logic [23:0]   mant;
      longint        acc;
      longint        y;
      w.value = '0;
      w.invalid = 1'b0;
      w.eob = eob;
      expf = bits[30:23];
      if (bits[31] || expf == 8'd0 || expf == 8'(EXP_ALL_ONES)) begin
         w.invalid = 1'b1;
      end else begin
         mant = {1'b1, bits[22:0]};
         acc = fixed_coef(K4_Q28) - scale_by_mant(fixed_coef(K5_Q28), mant);
         acc = -fixed_coef(K3_Q28) + scale_by_mant(acc, mant);
         acc = fixed_coef(K2_Q28) + scale_by_mant(acc, mant);
         acc = -fixed_coef(K1_Q28) + scale_by_mant(acc, mant);
         y = (longint'(expf) - EXP_BIAS) * fixed_coef(LN2_Q28) + acc;
         if (y > 64'sd2147483647) y = 64'sd2147483647;
         if (y < -64'sd2147483648) y = -64'sd2147483648;
         w.value = y[31:0];
      end
      return w;
   endfunction

   function automatic logic [31:0] random_sample();
      logic [31:0] b;
      int          pick;
      b = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         b[31] = 1'b0;
         b[30:23] = 8'($urandom_range(1, 254));
      end else if (pick < 80) begin
         b[31] = 1'b0;
         b[30:23] = 8'($urandom_range(125, 128));
      end else if (pick < 90) begin
         b[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'hFF;
      end
      return b;
   endfunction

   // driver: new word only once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            ln_due.push_back(predict_log(req_sample_bits, req_end_of_block));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 13);
               req_valid <= 1'b0;
            end else if (samples_queued.size() > 0) begin
               next_sample = samples_queued.pop_front();
               req_sample_bits <= next_sample.bits;
               req_end_of_block <= next_sample.eob;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each taken word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ln_due.size() == 0) begin
               $error("unexpected result word, log_value %h", rsp_log_value);
               fail_count++;
            end else begin
               due_word = ln_due.pop_front();
               if (rsp_log_value !== due_word.value) begin
                  $error("log_value expected %h actual %h", due_word.value, rsp_log_value);
                  fail_count++;
               end
               if (rsp_invalid_input !== due_word.invalid) begin
                  $error("invalid_input expected %b actual %b",
                         due_word.invalid, rsp_invalid_input);
                  fail_count++;
               end
               if (rsp_end_of_block_out !== due_word.eob) begin
                  $error("end_of_block_out expected %b actual %b",
                         due_word.eob, rsp_end_of_block_out);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] directed[$];
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
                   32'h7F80_0000, 32'h7FC0_0000, 32'hFF80_0000, 32'hFFFF_FFFF,
                   32'hBF80_0000, 32'h8080_0000, 32'h3F80_0000, 32'h3F80_0001,
                   32'h3FFF_FFFF, 32'h4000_0000, 32'h0080_0000, 32'h7F7F_FFFF,
                   32'h7F00_0000, 32'h3F7F_FFFF, 32'h402D_F854, 32'h00FF_FFFF,
                   32'h7F7F_0000, 32'h7FFF_FFFF};
      foreach (directed[i])
         samples_queued.push_back('{bits: directed[i], eob: 1'(i % 3 == 2)});
      for (int i = 0; i < RANDOM_WORDS; i++)
         samples_queued.push_back('{bits: random_sample(),
                                    eob: 1'($urandom_range(0, 7) == 0)});
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (samples_queued.size() >= CALM_WORDS) @(posedge clock);
      calm <= 1'b1;
      while (samples_queued.size() > 0 || req_valid || ln_due.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
